>>> hw/rtl/lsmp_pkg.sv
// Shared types, constants and the divisor table for the laser scan to map points block.
// Used by every module under hw/rtl; depends on nothing else.
package lsmp_pkg;

    localparam logic [63:0] PI4_Q64  = 64'hC90F_DAA2_2168_C235;
    localparam logic [63:0] HALF_LSB = 64'h0001_0000_0000_0000;

    localparam int APB_AW = 5;

    localparam logic [2:0] REG_RANGE_MIN   = 3'd0;
    localparam logic [2:0] REG_RANGE_MAX   = 3'd1;
    localparam logic [2:0] REG_ANGLE_START = 3'd2;
    localparam logic [2:0] REG_ANGLE_STEP  = 3'd3;
    localparam logic [2:0] REG_POSE_X      = 3'd4;
    localparam logic [2:0] REG_POSE_Y      = 3'd5;
    localparam logic [2:0] REG_POSE_YAW    = 3'd6;

    localparam logic [3:0] K_SIN_FIRST = 4'd1;
    localparam logic [3:0] K_SIN_LAST  = 4'd10;
    localparam logic [3:0] K_COS_FIRST = 4'd2;
    localparam logic [3:0] K_COS_LAST  = 4'd11;

    typedef enum logic [3:0] {
        S_IDLE,
        S_XMUL,
        S_X2MUL,
        S_SMUL,
        S_SDIV,
        S_CMUL,
        S_CDIV,
        S_FOLD,
        S_XSCL,
        S_YSCL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [8:0]  den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] value;
    } t_unit_rsp;

    typedef struct packed {
        logic        idle;
        logic        done;
        logic [17:0] off_x;
        logic [17:0] off_y;
    } t_seq_rsp;

    // Factorial step of the Taylor series: 2k(2k+1) for sine, (2k-1)2k for cosine
    function automatic logic [8:0] f_divisor(input logic is_cos, input logic [3:0] k);
        logic [8:0] d;
        unique case ({is_cos, k})
            {1'b0, 4'd1}:  d = 9'd6;
            {1'b0, 4'd2}:  d = 9'd20;
            {1'b0, 4'd3}:  d = 9'd42;
            {1'b0, 4'd4}:  d = 9'd72;
            {1'b0, 4'd5}:  d = 9'd110;
            {1'b0, 4'd6}:  d = 9'd156;
            {1'b0, 4'd7}:  d = 9'd210;
            {1'b0, 4'd8}:  d = 9'd272;
            {1'b0, 4'd9}:  d = 9'd342;
            {1'b0, 4'd10}: d = 9'd420;
            {1'b1, 4'd2}:  d = 9'd12;
            {1'b1, 4'd3}:  d = 9'd30;
            {1'b1, 4'd4}:  d = 9'd56;
            {1'b1, 4'd5}:  d = 9'd90;
            {1'b1, 4'd6}:  d = 9'd132;
            {1'b1, 4'd7}:  d = 9'd182;
            {1'b1, 4'd8}:  d = 9'd240;
            {1'b1, 4'd9}:  d = 9'd306;
            {1'b1, 4'd10}: d = 9'd380;
            {1'b1, 4'd11}: d = 9'd462;
            default:       d = 9'd1;
        endcase
        return d;
    endfunction

endpackage

>>> hw/rtl/lsmp_mulhi.sv
// Shared 64x64 high-half multiplier: one 32x32 multiplier, four partial products in turn.
// Depends on lsmp_pkg.
module lsmp_mulhi (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lsmp_pkg::t_mul_req   i_req,
    output lsmp_pkg::t_unit_rsp  o_rsp
);
    import lsmp_pkg::*;

    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [2:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [63:0] r_prod;
    logic [95:0] r_acc;

    logic [31:0] op_a;
    logic [31:0] op_b;
    logic [63:0] n_prod;
    logic [95:0] addend;
    logic [95:0] n_acc;

    always_comb begin
        unique case (r_cnt[1:0])
            2'd0: begin
                op_a = r_a[31:0];
                op_b = r_b[31:0];
            end
            2'd1: begin
                op_a = r_a[31:0];
                op_b = r_b[63:32];
            end
            2'd2: begin
                op_a = r_a[63:32];
                op_b = r_b[31:0];
            end
            default: begin
                op_a = r_a[63:32];
                op_b = r_b[63:32];
            end
        endcase
        n_prod = {32'b0, op_a} * {32'b0, op_b};
    end

    // low word of a0*b0 never reaches the high half, so only its top word is kept
    always_comb begin
        unique case (r_cnt)
            3'd1:       addend = {64'b0, r_prod[63:32]};
            3'd2, 3'd3: addend = {32'b0, r_prod};
            3'd4:       addend = {r_prod, 32'b0};
            default:    addend = '0;
        endcase
        n_acc = ((r_cnt == 3'd1) ? 96'b0 : r_acc) + addend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end
        if (r_busy) begin
            r_prod <= n_prod;
            if (r_cnt != 3'd0) begin
                r_acc <= n_acc;
            end
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_acc[95:32];

endmodule

>>> hw/rtl/lsmp_cdiv.sv
// Divider of a 64-bit word by a small constant, one quotient byte per cycle.
// Depends on lsmp_pkg.
module lsmp_cdiv (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lsmp_pkg::t_div_req   i_req,
    output lsmp_pkg::t_unit_rsp  o_rsp
);
    import lsmp_pkg::*;

    logic [63:0] r_num;
    logic [8:0]  r_rem;
    logic [63:0] r_quo;
    logic [8:0]  r_den;
    logic [2:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [16:0] part;
    logic [7:0]  digit;

    // restoring long division of one byte; remainder stays below the divisor
    always_comb begin
        part  = {r_rem, r_num[63:56]};
        digit = '0;
        for (int i = 7; i >= 0; i--) begin
            if (part >= (17'(r_den) << i)) begin
                part     = part - (17'(r_den) << i);
                digit[i] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_num <= {r_num[55:0], 8'b0};
            r_quo <= {r_quo[55:0], digit};
            r_rem <= part[8:0];
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_quo;

endmodule

>>> hw/rtl/lsmp_seq.sv
// Sequencer: folds the angle, runs the sine and cosine series and the range scaling
// on the shared multiplier and the constant divider. Depends on lsmp_pkg, lsmp_mulhi, lsmp_cdiv.
module lsmp_seq #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_take,
    input  logic                   i_in_range,
    input  logic [15:0]            i_range,
    input  logic [ANGLE_BITS-1:0]  i_theta,
    output lsmp_pkg::t_seq_rsp     o_rsp
);
    import lsmp_pkg::*;

    localparam int FRAC_W  = ANGLE_BITS - 2;
    localparam int X_SHIFT = 67 - ANGLE_BITS;
    localparam logic [FRAC_W-1:0] EIGHTH = FRAC_W'(1) << (ANGLE_BITS - 3);

    t_state r_state;
    t_state n_state;
    logic   r_kick;

    logic [15:0]       r_range;
    logic [FRAC_W-1:0] r_u;
    logic              r_swap;
    logic [1:0]        r_q;
    logic [63:0]       r_x;
    logic [63:0]       r_x2;
    logic [63:0]       r_term;
    logic [63:0]       r_s;
    logic [63:0]       r_c;
    logic [3:0]        r_k;
    logic [14:0]       r_cmag;
    logic              r_cneg;
    logic [14:0]       r_smag;
    logic              r_sneg;
    logic [17:0]       r_off_x;
    logic [17:0]       r_off_y;

    t_mul_req  mul_req;
    t_div_req  div_req;
    t_unit_rsp mul_rsp;
    t_unit_rsp div_rsp;

    logic [FRAC_W-1:0] frac;
    logic              n_swap;
    logic [FRAC_W-1:0] n_u;
    logic [63:0]       sum_s;
    logic [63:0]       sum_c;
    logic [15:0]       sm;
    logic [15:0]       cm;
    logic [15:0]       s0w;
    logic [15:0]       c0w;
    logic [14:0]       s0;
    logic [14:0]       c0;
    logic [14:0]       n_cmag;
    logic              n_cneg;
    logic [14:0]       n_smag;
    logic              n_sneg;
    logic [31:0]       sc_sum;
    logic [16:0]       sc_mag;
    logic              sc_neg;
    logic [17:0]       n_off;

    lsmp_mulhi u_mulhi (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    lsmp_cdiv u_cdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // fold theta into 0..1/8 turn
    always_comb begin
        frac   = i_theta[FRAC_W-1:0];
        n_swap = frac > EIGHTH;
        n_u    = n_swap ? (FRAC_W'(0) - frac) : frac;
    end

    // magnitudes, saturation, octant swap and quadrant signs
    always_comb begin
        sum_s = r_s + HALF_LSB;
        sum_c = r_c + HALF_LSB;
        sm    = {1'b0, sum_s[63:49]};
        cm    = 16'd32768 - {1'b0, sum_c[63:49]};
        s0w   = r_swap ? cm : sm;
        c0w   = r_swap ? sm : cm;
        s0    = s0w[15] ? 15'h7FFF : s0w[14:0];
        c0    = c0w[15] ? 15'h7FFF : c0w[14:0];
        unique case (r_q)
            2'd0: begin
                n_cmag = c0; n_cneg = 1'b0; n_smag = s0; n_sneg = 1'b0;
            end
            2'd1: begin
                n_cmag = s0; n_cneg = 1'b1; n_smag = c0; n_sneg = 1'b0;
            end
            2'd2: begin
                n_cmag = c0; n_cneg = 1'b1; n_smag = s0; n_sneg = 1'b1;
            end
            default: begin
                n_cmag = s0; n_cneg = 1'b0; n_smag = c0; n_sneg = 1'b1;
            end
        endcase
    end

    // round range * |t| / 2^15 half away from zero, then sign
    always_comb begin
        sc_sum = mul_rsp.value[31:0] + 32'd16384;
        sc_mag = sc_sum[31:15];
        sc_neg = (r_state == S_XSCL) ? r_cneg : r_sneg;
        n_off  = sc_neg ? (18'd0 - {1'b0, sc_mag}) : {1'b0, sc_mag};
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (!i_in_range) begin
                        n_state = S_DONE;
                    end else if (n_u == EIGHTH) begin
                        n_state = S_X2MUL;
                    end else begin
                        n_state = S_XMUL;
                    end
                end
            end
            S_XMUL:  if (mul_rsp.done) n_state = S_X2MUL;
            S_X2MUL: if (mul_rsp.done) n_state = S_SMUL;
            S_SMUL:  if (mul_rsp.done) n_state = S_SDIV;
            S_SDIV: begin
                if (div_rsp.done) begin
                    n_state = (r_k == K_SIN_LAST) ? S_CMUL : S_SMUL;
                end
            end
            S_CMUL:  if (mul_rsp.done) n_state = S_CDIV;
            S_CDIV: begin
                if (div_rsp.done) begin
                    n_state = (r_k == K_COS_LAST) ? S_FOLD : S_CMUL;
                end
            end
            S_FOLD:  n_state = S_XSCL;
            S_XSCL:  if (mul_rsp.done) n_state = S_YSCL;
            S_YSCL:  if (mul_rsp.done) n_state = S_DONE;
            S_DONE:  if (i_take) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mul_req       = '0;
        div_req       = '0;
        mul_req.start = r_kick && (r_state == S_XMUL || r_state == S_X2MUL ||
                        r_state == S_SMUL || r_state == S_CMUL ||
                        r_state == S_XSCL || r_state == S_YSCL);
        div_req.start = r_kick && (r_state == S_SDIV || r_state == S_CDIV);
        div_req.num   = r_term;
        div_req.den   = f_divisor(r_state == S_CDIV, r_k);
        unique case (r_state)
            S_XMUL: begin
                mul_req.a = PI4_Q64;
                mul_req.b = 64'(r_u[ANGLE_BITS-4:0]) << X_SHIFT;
            end
            S_X2MUL: begin
                mul_req.a = r_x;
                mul_req.b = r_x;
            end
            S_SMUL, S_CMUL: begin
                mul_req.a = r_term;
                mul_req.b = r_x2;
            end
            S_XSCL: begin
                mul_req.a = 64'(r_range) << 32;
                mul_req.b = 64'(r_cmag) << 32;
            end
            S_YSCL: begin
                mul_req.a = 64'(r_range) << 32;
                mul_req.b = 64'(r_smag) << 32;
            end
            default: begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
        o_rsp.idle  = (r_state == S_IDLE);
        o_rsp.done  = (r_state == S_DONE);
        o_rsp.off_x = r_off_x;
        o_rsp.off_y = r_off_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kick  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_kick  <= (n_state != r_state);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_range <= i_range;
                    r_u     <= n_u;
                    r_swap  <= n_swap;
                    r_q     <= i_theta[ANGLE_BITS-1:ANGLE_BITS-2];
                    r_x     <= PI4_Q64;
                end
            end
            S_XMUL: begin
                if (mul_rsp.done) r_x <= mul_rsp.value;
            end
            S_X2MUL: begin
                if (mul_rsp.done) begin
                    r_x2   <= mul_rsp.value;
                    r_term <= r_x;
                    r_s    <= r_x;
                    r_k    <= K_SIN_FIRST;
                end
            end
            S_SMUL, S_CMUL: begin
                if (mul_rsp.done) r_term <= mul_rsp.value;
            end
            S_SDIV: begin
                if (div_rsp.done) begin
                    r_s <= r_k[0] ? (r_s - div_rsp.value) : (r_s + div_rsp.value);
                    if (r_k == K_SIN_LAST) begin
                        r_term <= r_x2 >> 1;
                        r_c    <= r_x2 >> 1;
                        r_k    <= K_COS_FIRST;
                    end else begin
                        r_term <= div_rsp.value;
                        r_k    <= r_k + 4'd1;
                    end
                end
            end
            S_CDIV: begin
                if (div_rsp.done) begin
                    r_c    <= r_k[0] ? (r_c + div_rsp.value) : (r_c - div_rsp.value);
                    r_term <= div_rsp.value;
                    r_k    <= r_k + 4'd1;
                end
            end
            S_FOLD: begin
                r_cmag <= n_cmag;
                r_cneg <= n_cneg;
                r_smag <= n_smag;
                r_sneg <= n_sneg;
            end
            S_XSCL: begin
                if (mul_rsp.done) r_off_x <= n_off;
            end
            S_YSCL: begin
                if (mul_rsp.done) r_off_y <= n_off;
            end
            default: begin
            end
        endcase
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("start while sequencer busy");

    a_units_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_rsp.done && div_rsp.done))
        else $error("multiplier and divider finished together");

    a_sin_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SMUL || r_state == S_SDIV) |->
        (r_k >= K_SIN_FIRST && r_k <= K_SIN_LAST))
        else $error("sine term index out of range");

    a_cos_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMUL || r_state == S_CDIV) |->
        (r_k >= K_COS_FIRST && r_k <= K_COS_LAST))
        else $error("cosine term index out of range");

    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_take) |=> (r_state == S_DONE))
        else $error("result dropped before output slot freed");

endmodule

>>> hw/rtl/laser_scan_to_map_points_core.sv
// Laser scan to map points: beam angle tracking, APB registers, stream ports, output word.
// Depends on lsmp_pkg and lsmp_seq.
// An in-range beam runs 24 products on the shared 32x32 multiplier (four partials each, 23
// products when the folded angle is exactly an eighth of a turn) and 20 divisions in the
// constant divider at one quotient byte per cycle; an out-of-range beam skips them all.
// One beam at a time: the next beam is taken only once the sequencer is idle again, which
// waits until the output slot is free.
// Synchronous active-low reset: registers to defaults, next beam starts a scan, no word held.
module laser_scan_to_map_points_core #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,  // range_mm[15:0]
    input  logic                          s_axis_tlast,  // last_beam
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [63:0]                   m_axis_tdata,  // map_x[31:0], map_y[63:32]
    output logic                          m_axis_tuser,  // point_valid
    output logic                          m_axis_tlast,  // last_point
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lsmp_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import lsmp_pkg::*;

    logic [15:0]           r_range_min;
    logic [15:0]           r_range_max;
    logic [ANGLE_BITS-1:0] r_angle_start;
    logic [ANGLE_BITS-1:0] r_angle_step;
    logic [30:0]           r_pose_x;
    logic [30:0]           r_pose_y;
    logic [ANGLE_BITS-1:0] r_pose_yaw;
    logic [ANGLE_BITS-1:0] r_beam_angle;
    logic                  r_scan_start;
    logic                  r_item_valid;
    logic                  r_item_last;
    logic                  r_out_valid;
    logic [63:0]           r_out_data;
    logic                  r_out_user;
    logic                  r_out_last;

    logic                  cfg_we;
    logic [2:0]            reg_idx;
    logic                  in_accept;
    logic [ANGLE_BITS-1:0] cur_angle;
    logic [ANGLE_BITS-1:0] theta;
    logic                  in_range;
    logic                  out_take;
    logic                  out_load;
    logic [31:0]           n_map_x;
    logic [31:0]           n_map_y;
    t_seq_rsp              seq_rsp;

    assign pready    = 1'b1;
    assign cfg_we    = psel & penable & pwrite & pready;
    assign reg_idx   = paddr[4:2];
    assign in_accept = s_axis_tvalid & s_axis_tready;
    assign cur_angle = r_scan_start ? r_angle_start : r_beam_angle;
    assign theta     = cur_angle + r_pose_yaw;
    assign in_range  = (s_axis_tdata > r_range_min) && (s_axis_tdata < r_range_max);
    assign out_take  = !r_out_valid || m_axis_tready;
    assign out_load  = seq_rsp.done && out_take;

    assign s_axis_tready = seq_rsp.idle;

    lsmp_seq #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_accept),
        .i_take     (out_take),
        .i_in_range (in_range),
        .i_range    (s_axis_tdata),
        .i_theta    (theta),
        .o_rsp      (seq_rsp)
    );

    always_comb begin
        n_map_x = '0;
        n_map_y = '0;
        if (r_item_valid) begin
            n_map_x = {r_pose_x[30], r_pose_x} + {{14{seq_rsp.off_x[17]}}, seq_rsp.off_x};
            n_map_y = {r_pose_y[30], r_pose_y} + {{14{seq_rsp.off_y[17]}}, seq_rsp.off_y};
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RANGE_MIN:   prdata = {16'b0, r_range_min};
            REG_RANGE_MAX:   prdata = {16'b0, r_range_max};
            REG_ANGLE_START: prdata = 32'($signed(r_angle_start));
            REG_ANGLE_STEP:  prdata = 32'($signed(r_angle_step));
            REG_POSE_X:      prdata = 32'($signed(r_pose_x));
            REG_POSE_Y:      prdata = 32'($signed(r_pose_y));
            REG_POSE_YAW:    prdata = 32'(r_pose_yaw);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min   <= '0;
            r_range_max   <= 16'hFFFF;
            r_angle_start <= '0;
            r_angle_step  <= '0;
            r_pose_x      <= '0;
            r_pose_y      <= '0;
            r_pose_yaw    <= '0;
        end else if (cfg_we) begin
            unique case (reg_idx)
                REG_RANGE_MIN:   r_range_min   <= pwdata[15:0];
                REG_RANGE_MAX:   r_range_max   <= pwdata[15:0];
                REG_ANGLE_START: r_angle_start <= ANGLE_BITS'($signed(pwdata[15:0]));
                REG_ANGLE_STEP:  r_angle_step  <= ANGLE_BITS'($signed(pwdata[15:0]));
                REG_POSE_X:      r_pose_x      <= pwdata[30:0];
                REG_POSE_Y:      r_pose_y      <= pwdata[30:0];
                REG_POSE_YAW:    r_pose_yaw    <= ANGLE_BITS'(pwdata[15:0]);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beam_angle <= '0;
            r_scan_start <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_accept) begin
                r_beam_angle <= cur_angle + r_angle_step;
                r_scan_start <= s_axis_tlast;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item_valid <= in_range;
            r_item_last  <= s_axis_tlast;
        end
        if (out_load) begin
            r_out_data <= {n_map_y, n_map_x};
            r_out_user <= r_item_valid;
            r_out_last <= r_item_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !s_axis_tready)
        else $error("ready still high after taking a word");

    a_quick_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !in_range) |=> seq_rsp.done)
        else $error("out-of-range beam not finished at once");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> m_axis_tvalid)
        else $error("finished word not presented");

endmodule
